/* hw/rtl/key_matrix_debounce_scanner_core_assert.svh */
// ----------------------------------------------------------------------------
// key matrix scanner assertion macros
// concurrent checks clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_CORE_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg
// shared constants and types of the key matrix debounce scanner
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROW_COUNT      = 16;
    localparam int COLUMN_COUNT   = 8;
    localparam int READING_W      = 16;
    localparam int COL_IDX_W      = 3;
    localparam int QUERY_W        = 4;
    localparam int DEBOUNCE_W     = 8;
    localparam int ROW_BITS_W     = 8;
    localparam int COUNT_OUT_W    = 8;
    localparam int COUNT_OUT_MAX  = 255;
    localparam int TOTAL_KEYS     = ROW_COUNT * COLUMN_COUNT;
    localparam int COUNT_W        = $clog2(TOTAL_KEYS + 1);
    localparam int ROW_CNT_W      = $clog2(ROW_COUNT + 1);
    localparam int PAD_W          = (COLUMN_COUNT > ROW_BITS_W) ? COLUMN_COUNT : ROW_BITS_W;
    localparam int COUNT_EXT_W    = (COUNT_W > COUNT_OUT_W) ? COUNT_W : COUNT_OUT_W;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(10);

    typedef logic [COLUMN_COUNT-1:0] t_row;

    typedef struct packed {
        logic fire;
        t_row col_mask;
    } t_lane_ctrl;

    typedef struct packed {
        logic changed;
        logic rise;
        logic fall;
    } t_lane_stat;

endpackage

/* hw/rtl/kmd_item_if.sv */
// ----------------------------------------------------------------------------
// kmd_in_if / kmd_out_if
// valid/ready channels carrying scan items and results
// ----------------------------------------------------------------------------
interface kmd_in_if;

    logic                             valid;
    logic                             ready;
    logic [kmd_pkg::COL_IDX_W-1:0]    column_index;
    logic [kmd_pkg::READING_W-1:0]    row_readings;
    logic                             scan_end;
    logic [kmd_pkg::QUERY_W-1:0]      query_row;

    modport source (
        output valid, column_index, row_readings, scan_end, query_row,
        input  ready
    );

    modport sink (
        input  valid, column_index, row_readings, scan_end, query_row,
        output ready
    );

endinterface

interface kmd_out_if;

    logic                             valid;
    logic                             ready;
    logic                             settled;
    logic [kmd_pkg::ROW_BITS_W-1:0]   stable_row_bits;
    logic [kmd_pkg::COUNT_OUT_W-1:0]  pressed_count;
    logic                             column_changed;

    modport source (
        output valid, settled, stable_row_bits, pressed_count, column_changed,
        input  ready
    );

    modport sink (
        input  valid, settled, stable_row_bits, pressed_count, column_changed,
        output ready
    );

endinterface

/* hw/rtl/kmd_lane.sv */
// ----------------------------------------------------------------------------
// kmd_lane
// one matrix row: raw and stable key bits, compare and update of one column
// ----------------------------------------------------------------------------
module kmd_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmd_pkg::t_lane_ctrl  i_ctrl,
    input  logic                 i_copy,
    input  logic                 i_now,
    output kmd_pkg::t_lane_stat  o_stat,
    output kmd_pkg::t_row        o_stable_n
);

    kmd_pkg::t_row r_raw;
    kmd_pkg::t_row r_stable;
    kmd_pkg::t_row n_raw;
    logic          was;
    logic          hit;

    always_comb begin
        hit            = |i_ctrl.col_mask;
        was            = |(r_raw & i_ctrl.col_mask);
        o_stat.changed = hit && (i_now != was);
        o_stat.rise    = o_stat.changed && i_now;
        o_stat.fall    = o_stat.changed && !i_now;
        n_raw          = i_now ? (r_raw | i_ctrl.col_mask) : (r_raw & ~i_ctrl.col_mask);
    end

    assign o_stable_n = i_copy ? n_raw : r_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= '0;
            r_stable <= '0;
        end else if (i_ctrl.fire) begin
            r_raw    <= n_raw;
            r_stable <= o_stable_n;
        end
    end

endmodule

/* hw/rtl/kmd_merge.sv */
// ----------------------------------------------------------------------------
// kmd_merge
// combines lane results: change flag, settle counter, key counts
// ----------------------------------------------------------------------------
`include "key_matrix_debounce_scanner_core_assert.svh"

module kmd_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kmd_pkg::DEBOUNCE_W-1:0]      i_cfg_wdata,
    input  logic                                i_fire,
    input  logic                                i_scan_end,
    input  kmd_pkg::t_lane_stat                 i_stat [kmd_pkg::ROW_COUNT],
    output logic                                o_copy,
    output logic                                o_changed,
    output logic                                o_settled_n,
    output logic [kmd_pkg::COUNT_W-1:0]         o_count_n
);

    logic [kmd_pkg::DEBOUNCE_W-1:0] r_debounce;
    logic [kmd_pkg::DEBOUNCE_W-1:0] r_cnt;
    logic [kmd_pkg::DEBOUNCE_W-1:0] n_cnt;
    logic [kmd_pkg::COUNT_W-1:0]    r_raw_count;
    logic [kmd_pkg::COUNT_W-1:0]    n_raw_count;
    logic [kmd_pkg::COUNT_W-1:0]    r_stable_count;
    logic [kmd_pkg::DEBOUNCE_W-1:0] cnt_load;
    logic [kmd_pkg::ROW_COUNT-1:0]  changed_vec;
    logic [kmd_pkg::ROW_COUNT-1:0]  rise_vec;
    logic [kmd_pkg::ROW_COUNT-1:0]  fall_vec;
    logic [kmd_pkg::ROW_CNT_W-1:0]  ups;
    logic [kmd_pkg::ROW_CNT_W-1:0]  downs;
    logic                           dec;

    always_comb begin
        for (int r = 0; r < kmd_pkg::ROW_COUNT; r++) begin
            changed_vec[r] = i_stat[r].changed;
            rise_vec[r]    = i_stat[r].rise;
            fall_vec[r]    = i_stat[r].fall;
        end
        o_changed   = |changed_vec;
        ups         = kmd_pkg::ROW_CNT_W'($countones(rise_vec));
        downs       = kmd_pkg::ROW_CNT_W'($countones(fall_vec));
        n_raw_count = r_raw_count + kmd_pkg::COUNT_W'(ups) - kmd_pkg::COUNT_W'(downs);

        if (o_changed) begin
            cnt_load = (r_debounce == '0) ? kmd_pkg::DEBOUNCE_W'(1) : r_debounce;
        end else begin
            cnt_load = r_cnt;
        end
        dec         = i_scan_end && (cnt_load != '0);
        n_cnt       = dec ? (cnt_load - kmd_pkg::DEBOUNCE_W'(1)) : cnt_load;
        o_copy      = dec && (cnt_load == kmd_pkg::DEBOUNCE_W'(1));
        o_settled_n = (n_cnt == '0);
        o_count_n   = o_copy ? n_raw_count : r_stable_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce     <= kmd_pkg::DEBOUNCE_RESET;
            r_cnt          <= kmd_pkg::DEBOUNCE_RESET;
            r_raw_count    <= '0;
            r_stable_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_cnt          <= n_cnt;
                r_raw_count    <= n_raw_count;
                r_stable_count <= o_count_n;
            end
        end
    end

    `KMD_ASSERT_NXT(a_reload_nonzero, i_fire && o_changed && !i_scan_end, r_cnt != '0, "change without scan end left counter at zero")
    `KMD_ASSERT_NOW(a_settled_counts, r_cnt == '0, r_stable_count == r_raw_count, "settled but stable count differs from raw count")
    `KMD_ASSERT_NOW(a_count_bound, 1'b1, r_raw_count <= kmd_pkg::COUNT_W'(kmd_pkg::TOTAL_KEYS), "raw key count above matrix size")

endmodule

/* hw/rtl/key_matrix_debounce_scanner_core.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_core
// key matrix scanner with global debounce, one lane per matrix row
// ----------------------------------------------------------------------------
// i_item carries one column reading: column index, row bits, scan end flag
// and the row to report. o_result carries settled flag, stable bits of the
// queried row, stable key count and the column change flag.
// i_cfg_we / i_cfg_wdata write the debounce length, taken by later reloads.
// every row lane compares and updates its bit of the column in the accept
// cycle, the merge stage updates the settle counter and key counts, and the
// result is captured in an output register on the edge that accepts the item.
// throughput is one item per cycle while the output register is empty or
// being taken, set by the lane update and counter step.
// reset clears both matrices and counts, loads debounce length and counter
// with 10 and empties the output register.
// when the receiver stalls, the result is held and i_item.ready drops only
// while the output register is full and not taken.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kmd_pkg::DEBOUNCE_W-1:0]  i_cfg_wdata,
    kmd_in_if.sink                          i_item,
    kmd_out_if.source                       o_result
);

    logic                               fire;
    logic                               copy;
    logic                               changed;
    logic                               settled_n;
    logic [kmd_pkg::COUNT_W-1:0]        count_n;
    logic [kmd_pkg::COUNT_EXT_W-1:0]    count_ext;
    logic [kmd_pkg::READING_W-1:0]      readings;
    kmd_pkg::t_row                      col_mask;
    kmd_pkg::t_lane_ctrl                lane_ctrl;
    kmd_pkg::t_lane_stat                stat [kmd_pkg::ROW_COUNT];
    kmd_pkg::t_row                      stable_n [kmd_pkg::ROW_COUNT];
    kmd_pkg::t_row                      query_bits;
    logic [kmd_pkg::PAD_W-1:0]          query_pad;

    logic                               r_out_valid;
    logic                               r_settled;
    logic [kmd_pkg::ROW_BITS_W-1:0]     r_row_bits;
    logic [kmd_pkg::COUNT_OUT_W-1:0]    r_pressed;
    logic                               r_changed;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign fire         = i_item.valid && i_item.ready;
    assign readings     = i_item.row_readings;

    always_comb begin
        for (int c = 0; c < kmd_pkg::COLUMN_COUNT; c++) begin
            col_mask[c] = (int'(i_item.column_index) == c);
        end
        lane_ctrl.fire     = fire;
        lane_ctrl.col_mask = col_mask;
    end

    for (genvar r = 0; r < kmd_pkg::ROW_COUNT; r++) begin : g_lane
        logic now_bit;
        if (r < kmd_pkg::READING_W) begin : g_read
            assign now_bit = readings[r];
        end else begin : g_zero
            assign now_bit = 1'b0;
        end
        kmd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (lane_ctrl),
            .i_copy     (copy),
            .i_now      (now_bit),
            .o_stat     (stat[r]),
            .o_stable_n (stable_n[r])
        );
    end

    kmd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_scan_end  (i_item.scan_end),
        .i_stat      (stat),
        .o_copy      (copy),
        .o_changed   (changed),
        .o_settled_n (settled_n),
        .o_count_n   (count_n)
    );

    always_comb begin
        query_bits = '0;
        for (int r = 0; r < kmd_pkg::ROW_COUNT; r++) begin
            if (int'(i_item.query_row) == r) begin
                query_bits = stable_n[r];
            end
        end
        query_pad = kmd_pkg::PAD_W'(query_bits);
        count_ext = kmd_pkg::COUNT_EXT_W'(count_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_settled  <= settled_n;
            r_row_bits <= query_pad[kmd_pkg::ROW_BITS_W-1:0];
            r_changed  <= changed;
            if (count_ext > kmd_pkg::COUNT_EXT_W'(kmd_pkg::COUNT_OUT_MAX)) begin
                r_pressed <= kmd_pkg::COUNT_OUT_W'(kmd_pkg::COUNT_OUT_MAX);
            end else begin
                r_pressed <= count_ext[kmd_pkg::COUNT_OUT_W-1:0];
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.settled         = r_settled;
    assign o_result.stable_row_bits = r_row_bits;
    assign o_result.pressed_count   = r_pressed;
    assign o_result.column_changed  = r_changed;

endmodule
